// File: sv/cfs_pkg.sv
// shared types and constants of the command to can frame segmenter
package cfs_pkg;

  localparam int CHUNK_BYTES = 7;
  localparam int STORE_DEPTH = 7;
  localparam int FILL_W      = 3;
  localparam int LEN_W       = 4;

  typedef enum logic [1:0] {
    PH_ADDR    = 2'd0,
    PH_FUNC    = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef struct packed {
    logic [15:0]                  frame_id;
    logic [LEN_W-1:0]             frame_len;
    logic [7:0]                   byte0;
    logic [STORE_DEPTH-1:0][7:0]  data;
    logic                         frame_last;
  } frame_t;

endpackage

// File: sv/command_to_can_frame_segmenter.sv
// top level of the command to can frame segmenter
// Takes a command one byte per request (address, function code, payload, is_last on
// the final byte) and gives one CAN frame (16-bit id) for every chunk of up to seven
// payload bytes: id = address * 256 + packet number, byte0 = function code, unused
// bytes zero. A command of two bytes or fewer gives no frame. One byte is taken every
// cycle while input is not stalled; a frame is registered in an output register backed
// by a skid stage, which takes it while the output register holds an untaken frame, so
// input is stalled only when both hold frames that the receiver has not taken.
module command_to_can_frame_segmenter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_cmd_byte,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_frame_id,
  output logic [3:0]  out_frame_len,
  output logic [7:0]  out_byte0,
  output logic [7:0]  out_byte1,
  output logic [7:0]  out_byte2,
  output logic [7:0]  out_byte3,
  output logic [7:0]  out_byte4,
  output logic [7:0]  out_byte5,
  output logic [7:0]  out_byte6,
  output logic [7:0]  out_byte7,
  output logic        out_frame_last
);

  logic            byte_acc;
  logic            frm_vld;
  logic            buf_full;
  cfs_pkg::frame_t frm;
  cfs_pkg::frame_t out_frm;

  assign in_stall = buf_full;
  assign byte_acc = in_valid && !buf_full;

  cfs_assembler u_asm (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_acc (byte_acc),
    .cmd_byte (in_cmd_byte),
    .is_last  (in_is_last),
    .frm_vld  (frm_vld),
    .frm      (frm)
  );

  cfs_out_buf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (frm_vld),
    .push_frm (frm),
    .full     (buf_full),
    .out_vld  (out_valid),
    .out_stl  (out_stall),
    .out_frm  (out_frm)
  );

  assign out_frame_id   = out_frm.frame_id;
  assign out_frame_len  = out_frm.frame_len;
  assign out_byte0      = out_frm.byte0;
  assign out_byte1      = out_frm.data[0];
  assign out_byte2      = out_frm.data[1];
  assign out_byte3      = out_frm.data[2];
  assign out_byte4      = out_frm.data[3];
  assign out_byte5      = out_frm.data[4];
  assign out_byte6      = out_frm.data[5];
  assign out_byte7      = out_frm.data[6];
  assign out_frame_last = out_frm.frame_last;

endmodule

// File: sv/cfs_assembler.sv
// command parser and chunk assembler: turns accepted bytes into frame requests
module cfs_assembler (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             byte_acc,
  input  logic [7:0]       cmd_byte,
  input  logic             is_last,
  output logic             frm_vld,
  output cfs_pkg::frame_t  frm
);

  cfs_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] addr_r, addr_nxt;
  logic [7:0] func_r, func_nxt;
  logic [7:0] pkt_r, pkt_nxt;
  logic [cfs_pkg::FILL_W-1:0] fill_r, fill_nxt;
  logic [cfs_pkg::STORE_DEPTH-1:0][7:0] store_r, store_nxt;
  logic [cfs_pkg::LEN_W-1:0] fill_inc;
  logic [cfs_pkg::STORE_DEPTH-1:0][7:0] store_wr;
  logic emit;

  // next state
  always_comb begin
    phase_nxt = phase_r;
    if (byte_acc) begin
      case (phase_r)
        cfs_pkg::PH_FUNC:    phase_nxt = is_last ? cfs_pkg::PH_ADDR : cfs_pkg::PH_PAYLOAD;
        cfs_pkg::PH_PAYLOAD: phase_nxt = is_last ? cfs_pkg::PH_ADDR : cfs_pkg::PH_PAYLOAD;
        default:             phase_nxt = is_last ? cfs_pkg::PH_ADDR : cfs_pkg::PH_FUNC;
      endcase
    end
  end

  // chunk store with the new byte written at the fill position
  always_comb begin
    store_wr = store_r;
    if (32'(fill_r) < cfs_pkg::STORE_DEPTH) begin
      store_wr[fill_r] = cmd_byte;
    end
  end

  assign fill_inc = (32'(fill_r) < cfs_pkg::STORE_DEPTH) ?
                    cfs_pkg::LEN_W'(fill_r) + cfs_pkg::LEN_W'(1) :
                    cfs_pkg::LEN_W'(fill_r);

  // outputs and datapath
  always_comb begin
    addr_nxt  = addr_r;
    func_nxt  = func_r;
    pkt_nxt   = pkt_r;
    fill_nxt  = fill_r;
    store_nxt = store_r;
    emit      = 1'b0;
    frm.frame_id   = {addr_r, pkt_r};
    frm.frame_len  = fill_inc + cfs_pkg::LEN_W'(1);
    frm.byte0      = func_r;
    frm.data       = store_wr;
    frm.frame_last = is_last;
    if (byte_acc) begin
      case (phase_r)
        cfs_pkg::PH_FUNC: begin
          func_nxt = cmd_byte;
        end
        cfs_pkg::PH_PAYLOAD: begin
          // entries beyond the fill stay zero, so the store reads out as is
          if (32'(fill_inc) >= cfs_pkg::CHUNK_BYTES || is_last) begin
            emit      = 1'b1;
            pkt_nxt   = pkt_r + 8'd1;
            fill_nxt  = '0;
            store_nxt = '0;
          end else begin
            fill_nxt  = cfs_pkg::FILL_W'(fill_inc);
            store_nxt = store_wr;
          end
        end
        default: begin
          addr_nxt  = cmd_byte;
          func_nxt  = 8'h00;
          pkt_nxt   = 8'h00;
          fill_nxt  = '0;
          store_nxt = '0;
        end
      endcase
    end
  end

  assign frm_vld = emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= cfs_pkg::PH_ADDR;
      addr_r  <= 8'h00;
      func_r  <= 8'h00;
      pkt_r   <= 8'h00;
      fill_r  <= '0;
      store_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      addr_r  <= addr_nxt;
      func_r  <= func_nxt;
      pkt_r   <= pkt_nxt;
      fill_r  <= fill_nxt;
      store_r <= store_nxt;
    end
  end

endmodule

// File: sv/cfs_out_buf.sv
// two-entry output register with skid stage for frame requests
module cfs_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cfs_pkg::frame_t  push_frm,
  output logic             full,
  output logic             out_vld,
  input  logic             out_stl,
  output cfs_pkg::frame_t  out_frm
);

  logic            main_v_r, main_v_nxt;
  logic            skid_v_r, skid_v_nxt;
  cfs_pkg::frame_t main_r, main_nxt;
  cfs_pkg::frame_t skid_r, skid_nxt;
  logic            pop;

  assign pop     = main_v_r && !out_stl;
  assign full    = skid_v_r;
  assign out_vld = main_v_r;
  assign out_frm = main_r;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (skid_v_r) begin
      if (pop) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_v_r || pop) begin
        main_nxt   = push_frm;
        main_v_nxt = 1'b1;
      end else begin
        skid_nxt   = push_frm;
        skid_v_nxt = 1'b1;
      end
    end else if (pop) begin
      main_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule
